// ----- src/first_fit_range_allocator_macros.svh -----
// Assertion helpers shared by the checkers of the range allocator.
`ifndef FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FFRA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ffra check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FFRA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ffra check failed");

`endif

// ----- src/ffra_pkg.sv -----
package ffra_pkg;

  localparam int POOL_DEPTH = 64;
  // Page size; must be a power of two.
  localparam int PAGE_BYTES = 4096;

  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int IDX_W    = $clog2(POOL_DEPTH);
  localparam int LINK_W   = $clog2(POOL_DEPTH + 1);
  localparam int STEP_W   = $clog2(POOL_DEPTH + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [DATA_W-1:0] PAGE_MASK = DATA_W'(PAGE_BYTES - 1);
  localparam logic [LINK_W-1:0] LINK_NIL  = LINK_W'(POOL_DEPTH);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOFIT    = 2'd1,
    ST_NODESC   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RANGE_START = 1'b0,
    CFG_RANGE_END   = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROUND,
    S_WALK_RD,
    S_WALK_CHK,
    S_SPARE,
    S_SPLIT_B,
    S_SPLIT_W,
    S_CUR_W,
    S_FNX,
    S_FNX_MRG,
    S_FPV,
    S_FPV_MRG,
    S_FIX_RD,
    S_FIX_WR,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] len;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } desc_t;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              sub;
  } alu_req_t;

  function automatic logic link_nil(logic [LINK_W-1:0] link);
    return link >= LINK_NIL;
  endfunction

endpackage

// ----- src/ffra_ram.sv -----
module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ffra_alu.sv -----
module ffra_alu (
  input  ffra_pkg::alu_req_t          req_i,
  output logic [ffra_pkg::DATA_W-1:0] sum_o,
  output logic                        carry_o
);
  import ffra_pkg::*;

  logic [DATA_W-1:0] b_eff;

  // Subtract as a + ~b + 1; carry out set means no borrow (a >= b).
  assign b_eff = req_i.sub ? ~req_i.b : req_i.b;
  assign {carry_o, sum_o} = {1'b0, req_i.a} + {1'b0, b_eff} + {{DATA_W{1'b0}}, req_i.sub};

endmodule

// ----- src/first_fit_range_allocator.sv -----
// First-fit range allocator with coalescing.
// Input channel: in_valid_i / in_stall_o carries op_i (0 allocate, 1 free),
// request_size_i and release_addr_i; a transfer happens when valid is high
// and stall is low. Output channel: out_valid_o / out_stall_i carries
// block_addr_o and status_o, one result per request, in request order.
// Configuration: cfg_we_i writes cfg_data_i to range_start (index 0) or
// range_end (index 1) and rebuilds the pool as one free block; write only
// while no request is in flight.
// Operation: one request at a time. The chain walk reads one descriptor at a
// time from the descriptor RAM, from the head of the chain up to the first hit;
// a split adds a scan for a spare descriptor over the pool of 64 descriptors,
// and a free or a split ends with merge and link fix-up where needed.
// Reset clears the pool to one block covering an empty range; there is no
// clearing pass. A stalled result holds in the output register; the block
// takes the next request meanwhile but cannot deliver it until that clears.
module first_fit_range_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ffra_pkg::DATA_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           op_i,
  input  logic [ffra_pkg::DATA_W-1:0]    request_size_i,
  input  logic [ffra_pkg::DATA_W-1:0]    release_addr_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [ffra_pkg::DATA_W-1:0]    block_addr_o,
  output logic [ffra_pkg::STATUS_W-1:0]  status_o
);
  import ffra_pkg::*;

  state_e state_q, state_d;

  logic [POOL_DEPTH-1:0] taken_q, taken_d;
  logic [POOL_DEPTH-1:0] chain_q, chain_d;
  logic [POOL_DEPTH-1:0] valid_q, valid_d;

  logic [DATA_W-1:0] start_q, start_d;
  logic [DATA_W-1:0] end_q, end_d;
  logic [DATA_W-1:0] len0_q, len0_d;

  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] block_addr_q, block_addr_d;
  status_e           status_q, status_d;

  op_e               op_q, op_d;
  logic [DATA_W-1:0] size_q, size_d;
  logic [DATA_W-1:0] addr_q, addr_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [IDX_W-1:0]  spare_q, spare_d;
  logic [IDX_W-1:0]  fix_node_q, fix_node_d;
  logic [LINK_W-1:0] fix_prev_q, fix_prev_d;
  desc_t             desc_q, desc_d;
  desc_t             other_q, other_d;
  logic [DATA_W-1:0] res_addr_q, res_addr_d;
  status_e           res_st_q, res_st_d;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  desc_t             ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  desc_t             ram_rdata;
  logic              rd_valid_q;
  logic              rd_head_q;
  desc_t             rd;

  alu_req_t          alu_req;
  logic [DATA_W-1:0] alu_sum;
  logic              alu_carry;
  logic [DATA_W:0]   req_round;

  logic [DATA_W-1:0] new_start;
  logic [DATA_W-1:0] new_end;

  ffra_ram #(
    .WIDTH($bits(desc_t)),
    .DEPTH(POOL_DEPTH)
  ) u_desc_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  ffra_alu u_alu (
    .req_i  (alu_req),
    .sum_o  (alu_sum),
    .carry_o(alu_carry)
  );

  // Entries never written since the last rebuild read as their reset value.
  always_comb begin
    if (rd_valid_q) begin
      rd = ram_rdata;
    end else if (rd_head_q) begin
      rd = '{base: start_q, len: len0_q, next: LINK_NIL, prev: LINK_NIL};
    end else begin
      rd = '{base: '0, len: '0, next: LINK_NIL, prev: LINK_NIL};
    end
  end

  assign req_round = {alu_carry, alu_sum} & ~{1'b0, PAGE_MASK};

  assign new_start = (cfg_idx_i == CFG_RANGE_START) ? cfg_data_i : start_q;
  assign new_end   = (cfg_idx_i == CFG_RANGE_END) ? cfg_data_i : end_q;

  always_comb begin
    logic hit;
    hit          = 1'b0;
    state_d      = state_q;
    taken_d      = taken_q;
    chain_d      = chain_q;
    valid_d      = valid_q;
    start_d      = start_q;
    end_d        = end_q;
    len0_d       = len0_q;
    out_valid_d  = out_valid_q;
    block_addr_d = block_addr_q;
    status_d     = status_q;
    op_d         = op_q;
    size_d       = size_q;
    addr_d       = addr_q;
    cur_d        = cur_q;
    steps_d      = steps_q;
    spare_d      = spare_q;
    fix_node_d   = fix_node_q;
    fix_prev_d   = fix_prev_q;
    desc_d       = desc_q;
    other_d      = other_q;
    res_addr_d   = res_addr_q;
    res_st_d     = res_st_q;
    ram_we       = 1'b0;
    ram_waddr    = cur_q;
    ram_wdata    = desc_q;
    ram_raddr    = cur_q;
    alu_req      = '{a: desc_q.len, b: size_q, sub: 1'b1};

    // Drop the held result once it transfers.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_e'(op_i);
          size_d     = request_size_i;
          addr_d     = release_addr_i;
          cur_d      = '0;
          steps_d    = '0;
          res_addr_d = '0;
          res_st_d   = ST_OK;
          state_d    = (op_e'(op_i) == OP_ALLOC) ? S_ROUND : S_WALK_RD;
        end
      end
      S_ROUND: begin
        alu_req = '{a: size_q, b: PAGE_MASK, sub: 1'b0};
        if (req_round == '0 || req_round[DATA_W]) begin
          res_st_d = ST_NOFIT;
          state_d  = S_DONE;
        end else begin
          size_d  = req_round[DATA_W-1:0];
          state_d = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        ram_raddr = cur_q;
        state_d   = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        alu_req = '{a: rd.len, b: size_q, sub: 1'b1};
        if (op_q == OP_ALLOC) begin
          hit = !taken_q[cur_q] && alu_carry;
        end else begin
          hit = (rd.base == addr_q) && taken_q[cur_q];
        end
        if (hit) begin
          desc_d = rd;
          if (op_q == OP_ALLOC) begin
            if (alu_sum != '0) begin
              spare_d = '0;
              state_d = S_SPARE;
            end else begin
              taken_d[cur_q] = 1'b1;
              res_addr_d     = rd.base;
              state_d        = S_DONE;
            end
          end else begin
            taken_d[cur_q] = 1'b0;
            state_d        = S_FNX;
          end
        end else if (link_nil(rd.next) || steps_q == STEP_W'(POOL_DEPTH - 1)) begin
          res_st_d = (op_q == OP_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
          state_d  = S_DONE;
        end else begin
          cur_d   = rd.next[IDX_W-1:0];
          steps_d = steps_q + 1'b1;
          state_d = S_WALK_RD;
        end
      end
      S_SPARE: begin
        if (!chain_q[spare_q]) begin
          state_d = S_SPLIT_B;
        end else if (spare_q == IDX_W'(POOL_DEPTH - 1)) begin
          res_st_d = ST_NODESC;
          state_d  = S_DONE;
        end else begin
          spare_d = spare_q + 1'b1;
        end
      end
      S_SPLIT_B: begin
        alu_req      = '{a: desc_q.base, b: size_q, sub: 1'b0};
        other_d.base = alu_sum;
        state_d      = S_SPLIT_W;
      end
      S_SPLIT_W: begin
        alu_req   = '{a: desc_q.len, b: size_q, sub: 1'b1};
        ram_we    = 1'b1;
        ram_waddr = spare_q;
        ram_wdata = '{base: other_q.base, len: alu_sum, next: desc_q.next,
                      prev: LINK_W'(cur_q)};
        valid_d[spare_q] = 1'b1;
        chain_d[spare_q] = 1'b1;
        taken_d[spare_q] = 1'b0;
        other_d.next     = desc_q.next;
        desc_d.len       = size_q;
        desc_d.next      = LINK_W'(spare_q);
        state_d          = S_CUR_W;
      end
      S_CUR_W: begin
        ram_we         = 1'b1;
        ram_waddr      = cur_q;
        ram_wdata      = desc_q;
        valid_d[cur_q] = 1'b1;
        taken_d[cur_q] = 1'b1;
        res_addr_d     = desc_q.base;
        if (!link_nil(other_q.next)) begin
          fix_node_d = other_q.next[IDX_W-1:0];
          fix_prev_d = LINK_W'(spare_q);
          state_d    = S_FIX_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FNX: begin
        if (!link_nil(desc_q.next) && !taken_q[desc_q.next[IDX_W-1:0]]) begin
          ram_raddr = desc_q.next[IDX_W-1:0];
          state_d   = S_FNX_MRG;
        end else begin
          state_d = S_FPV;
        end
      end
      S_FNX_MRG: begin
        alu_req     = '{a: desc_q.len, b: rd.len, sub: 1'b0};
        desc_d.len  = alu_sum;
        desc_d.next = rd.next;
        valid_d[desc_q.next[IDX_W-1:0]] = 1'b0;
        chain_d[desc_q.next[IDX_W-1:0]] = 1'b0;
        taken_d[desc_q.next[IDX_W-1:0]] = 1'b0;
        state_d     = S_FPV;
      end
      S_FPV: begin
        if (!link_nil(desc_q.prev) && !taken_q[desc_q.prev[IDX_W-1:0]]) begin
          ram_raddr = desc_q.prev[IDX_W-1:0];
          state_d   = S_FPV_MRG;
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = cur_q;
          ram_wdata      = desc_q;
          valid_d[cur_q] = 1'b1;
          if (!link_nil(desc_q.next)) begin
            fix_node_d = desc_q.next[IDX_W-1:0];
            fix_prev_d = LINK_W'(cur_q);
            state_d    = S_FIX_RD;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_FPV_MRG: begin
        // Fold this block into its free predecessor and recycle it.
        alu_req   = '{a: rd.len, b: desc_q.len, sub: 1'b0};
        ram_we    = 1'b1;
        ram_waddr = desc_q.prev[IDX_W-1:0];
        ram_wdata = '{base: rd.base, len: alu_sum, next: desc_q.next, prev: rd.prev};
        valid_d[desc_q.prev[IDX_W-1:0]] = 1'b1;
        valid_d[cur_q] = 1'b0;
        chain_d[cur_q] = 1'b0;
        taken_d[cur_q] = 1'b0;
        if (!link_nil(desc_q.next)) begin
          fix_node_d = desc_q.next[IDX_W-1:0];
          fix_prev_d = desc_q.prev;
          state_d    = S_FIX_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FIX_RD: begin
        ram_raddr = fix_node_q;
        state_d   = S_FIX_WR;
      end
      S_FIX_WR: begin
        ram_we              = 1'b1;
        ram_waddr           = fix_node_q;
        ram_wdata           = rd;
        ram_wdata.prev      = fix_prev_q;
        valid_d[fix_node_q] = 1'b1;
        state_d             = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          block_addr_d = res_addr_q;
          status_d     = res_st_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Rebuild the pool as one free block on any range write.
    if (cfg_we_i) begin
      start_d    = new_start;
      end_d      = new_end;
      len0_d     = (new_end >= new_start) ? (new_end - new_start) : '0;
      taken_d    = '0;
      valid_d    = '0;
      chain_d    = '0;
      chain_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      taken_q     <= '0;
      chain_q     <= POOL_DEPTH'(1);
      valid_q     <= '0;
      start_q     <= '0;
      end_q       <= '0;
      len0_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      taken_q     <= taken_d;
      chain_q     <= chain_d;
      valid_q     <= valid_d;
      start_q     <= start_d;
      end_q       <= end_d;
      len0_q      <= len0_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    block_addr_q <= block_addr_d;
    status_q     <= status_d;
    op_q         <= op_d;
    size_q       <= size_d;
    addr_q       <= addr_d;
    cur_q        <= cur_d;
    steps_q      <= steps_d;
    spare_q      <= spare_d;
    fix_node_q   <= fix_node_d;
    fix_prev_q   <= fix_prev_d;
    desc_q       <= desc_d;
    other_q      <= other_d;
    res_addr_q   <= res_addr_d;
    res_st_q     <= res_st_d;
    rd_valid_q   <= valid_q[ram_raddr];
    rd_head_q    <= (ram_raddr == '0);
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign block_addr_o = block_addr_q;
  assign status_o     = status_q;

endmodule

// ----- src/ffra_chk.sv -----
`include "first_fit_range_allocator_macros.svh"

module ffra_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [ffra_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input logic [ffra_pkg::DATA_W-1:0]    cfg_data_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           op_i,
  input logic [ffra_pkg::DATA_W-1:0]    request_size_i,
  input logic [ffra_pkg::DATA_W-1:0]    release_addr_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [ffra_pkg::DATA_W-1:0]    block_addr_o,
  input logic [ffra_pkg::STATUS_W-1:0]  status_o
);
  import ffra_pkg::*;

  // A failed request never reports an address.
  `FFRA_ASSERT_NOW(a_fail_zero_addr, out_valid_o && (status_o != ST_OK), block_addr_o == '0)

  // The block is busy in the cycle after it takes a request.
  `FFRA_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)

  // No result appears in the cycle right after a transfer in.
  `FFRA_ASSERT_NEXT(a_no_instant_result, in_valid_i && !in_stall_o, !$rose(out_valid_o))

  // Hold a stalled result.
  `FFRA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
                    out_valid_o && $stable(block_addr_o) && $stable(status_o))

endmodule

bind first_fit_range_allocator ffra_chk u_ffra_chk (.*);

// ----- bench/first_fit_range_allocator_tb.sv -----
module first_fit_range_allocator_tb;
  import ffra_pkg::*;

  localparam int NIL = POOL_DEPTH;
  localparam int LIMIT_CYCLES = 4000000;

  typedef struct packed {
    op_e         op;
    logic [31:0] size;
    logic [31:0] addr;
    logic        hold;  // wait until all results are back before this one
  } req_t;

  typedef struct packed {
    logic [31:0] addr;
    status_e     status;
  } rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        op_i = 1'b0;
  logic [31:0] request_size_i = '0;
  logic [31:0] release_addr_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] block_addr_o;
  logic [STATUS_W-1:0] status_o;

  first_fit_range_allocator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .op_i, .request_size_i, .release_addr_i,
    .out_valid_o, .out_stall_i, .block_addr_o, .status_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow of the descriptor pool
  logic [31:0] sh_start, sh_end;
  logic [31:0] d_base[POOL_DEPTH];
  logic [31:0] d_len[POOL_DEPTH];
  bit          d_taken[POOL_DEPTH];
  bit          d_used[POOL_DEPTH];
  int          d_next[POOL_DEPTH];
  int          d_prev[POOL_DEPTH];
  logic [31:0] live_blocks[$];

  req_t  pending_reqs[$];
  rsp_t  expected_rsps[$];
  int    errors = 0;
  int    cycles = 0;

  function automatic void drop_desc(int i);
    d_base[i] = '0; d_len[i] = '0; d_taken[i] = 0; d_used[i] = 0;
    d_next[i] = NIL; d_prev[i] = NIL;
  endfunction

  function automatic void rebuild_pool();
    for (int i = 0; i < POOL_DEPTH; i++) drop_desc(i);
    d_used[0] = 1;
    d_base[0] = sh_start;
    d_len[0] = (sh_end >= sh_start) ? sh_end - sh_start : 32'd0;
    live_blocks.delete();
  endfunction

  function automatic rsp_t predict_alloc(logic [31:0] size);
    rsp_t r;
    logic [32:0] need;
    int cur, steps, n;
    r.addr = '0;
    need = ({1'b0, size} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);
    if (need == 0 || need[32]) begin
      r.status = ST_NOFIT;
      return r;
    end
    cur = 0; steps = 0;
    while (cur < NIL && steps < POOL_DEPTH) begin
      if (!d_taken[cur] && d_len[cur] >= need[31:0]) break;
      cur = d_next[cur]; steps++;
    end
    if (cur >= NIL || steps >= POOL_DEPTH) begin
      r.status = ST_NOFIT;
      return r;
    end
    if (d_len[cur] > need[31:0]) begin
      n = NIL;
      for (int i = POOL_DEPTH - 1; i >= 0; i--) if (!d_used[i]) n = i;
      if (n == NIL) begin
        r.status = ST_NODESC;
        return r;
      end
      d_used[n] = 1; d_taken[n] = 0;
      d_next[n] = d_next[cur]; d_prev[n] = cur;
      if (d_next[cur] < NIL) d_prev[d_next[cur]] = n;
      d_next[cur] = n;
      d_len[n] = d_len[cur] - need[31:0];
      d_base[n] = d_base[cur] + need[31:0];
      d_len[cur] = need[31:0];
    end
    d_taken[cur] = 1;
    r.addr = d_base[cur];
    r.status = ST_OK;
    live_blocks.push_back(r.addr);
    return r;
  endfunction

  function automatic rsp_t predict_free(logic [31:0] addr);
    rsp_t r;
    int cur, steps, nx, pv, nn;
    r.addr = '0;
    cur = 0; steps = 0;
    while (cur < NIL && steps < POOL_DEPTH) begin
      if (d_base[cur] == addr && d_taken[cur]) break;
      cur = d_next[cur]; steps++;
    end
    if (cur >= NIL || steps >= POOL_DEPTH) begin
      r.status = ST_NOTFOUND;
      return r;
    end
    d_taken[cur] = 0;
    foreach (live_blocks[i]) if (live_blocks[i] == addr) begin
      live_blocks.delete(i);
      break;
    end
    nx = d_next[cur];
    if (nx < NIL && !d_taken[nx]) begin
      nn = d_next[nx];
      d_next[cur] = nn;
      d_len[cur] += d_len[nx];
      if (nn < NIL) d_prev[nn] = cur;
      drop_desc(nx);
    end
    pv = d_prev[cur];
    if (pv < NIL && !d_taken[pv]) begin
      nn = d_next[cur];
      d_next[pv] = nn;
      d_len[pv] += d_len[cur];
      if (nn < NIL) d_prev[nn] = pv;
      drop_desc(cur);
    end
    r.status = ST_OK;
    return r;
  endfunction

  // Queue a request; the shadow advances when the driver sees it transfer.
  task automatic add_req(op_e op, logic [31:0] size, logic [31:0] addr, bit hold = 0);
    req_t q;
    q.op = op; q.size = size; q.addr = addr; q.hold = hold;
    pending_reqs.push_back(q);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 250);
  endfunction

  // Driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni && !cfg_we_i) begin
      if (in_valid_i && !in_stall_o) begin
        if (op_e'(op_i) == OP_ALLOC) expected_rsps.push_back(predict_alloc(request_size_i));
        else expected_rsps.push_back(predict_free(release_addr_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].hold &&
                       (expected_rsps.size() > 0 || (in_valid_i && !in_stall_o)))) begin
          req_t q;
          q = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          op_i <= q.op;
          request_size_i <= q.size;
          release_addr_i <= q.addr;
          in_gap <= gap_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor
  int out_gap = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result addr=%h status=%0d", $time, block_addr_o, status_o);
          errors++;
        end else begin
          rsp_t e;
          e = expected_rsps.pop_front();
          if (block_addr_o !== e.addr || status_o !== e.status) begin
            $display("%0t: expected addr=%h status=%0d, actual addr=%h status=%0d",
                     $time, e.addr, e.status, block_addr_o, status_o);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_gap <= gap_len();
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic settle();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CFG_RANGE_START) sh_start = val;
    else sh_end = val;
    rebuild_pool();
  endtask

  task automatic set_range(logic [31:0] s, logic [31:0] e);
    settle();
    write_reg(CFG_RANGE_START, s);
    write_reg(CFG_RANGE_END, e);
    cfg_we_i <= 1'b0;
  endtask

  // Random phase: mostly allocations that fit and frees of live blocks.
  // Requests are queued ahead, so frees target addresses predicted in a
  // scratch copy would be costly; draw from blocks already returned instead.
  task automatic random_phase(int count, logic [31:0] span);
    for (int k = 0; k < count; k++) begin
      int p;
      p = $urandom_range(0, 99);
      if (p < 50) add_req(OP_ALLOC, $urandom_range(1, span / 8 + 1), $urandom);
      else if (p < 58) add_req(OP_ALLOC, $urandom, $urandom);
      else if (p < 90 && live_blocks.size() > 0)
        add_req(OP_FREE, $urandom, live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
      else add_req(OP_FREE, $urandom, $urandom);
      // Let the pipeline drain now and then so the live list stays fresh.
      if ($urandom_range(0, 7) == 0) begin
        while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
          @(posedge clk_i);
      end
    end
  endtask

  initial begin
    sh_start = '0; sh_end = '0;
    rebuild_pool();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty range after reset
    add_req(OP_ALLOC, 32'd1, '0);
    add_req(OP_FREE, '0, '0);
    set_range(32'h0001_0000, 32'h0000_8000);  // end below start
    add_req(OP_ALLOC, 32'd4096, '0);
    set_range(32'h0000_0000, 32'h0000_4000);
    add_req(OP_ALLOC, 32'd0, '0);               // zero size
    add_req(OP_ALLOC, 32'hFFFF_FFFF, '0);       // oversized after rounding
    add_req(OP_ALLOC, 32'd1, '0);               // split
    add_req(OP_ALLOC, 32'd4097, '0);
    add_req(OP_ALLOC, 32'd4096, '0);            // exact fit of last block
    add_req(OP_ALLOC, 32'd1, '0);               // no fit
    add_req(OP_FREE, '0, 32'h0000_1000);
    add_req(OP_FREE, '0, 32'h0000_1000);        // unknown free
    add_req(OP_FREE, '0, 32'h0000_0000);        // merge next
    add_req(OP_FREE, '0, 32'h0000_3000);        // merge previous
    add_req(OP_ALLOC, 32'h0000_4000, '0, 1);
    add_req(OP_FREE, '0, 32'hFFFF_FFFF);
    set_range(32'h0010_0000, 32'h0010_0000 + 32'd70 * 4096);
    // Exhaust the descriptor pool
    for (int k = 0; k < 66; k++) add_req(OP_ALLOC, 32'd4096, '0);
    set_range(32'hFFFF_0000, 32'hFFFF_FFFF);
    add_req(OP_ALLOC, 32'hFFFF, '0);
    add_req(OP_ALLOC, 32'h1, '0);

    set_range(32'h0000_0000, 32'h0010_0000);
    random_phase(350, 32'h0010_0000);
    set_range(32'h8000_0000, 32'h8004_0000);
    random_phase(350, 32'h0004_0000);
    set_range(32'h0000_0000, 32'hFFFF_FFFF);
    random_phase(350, 32'hFFFF_FFFF);
    settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
